### hw/rtl/scc_pkg.sv
// types, character codes and character classes for the s-expression checker
package scc_pkg;

	localparam int unsigned CHAR_W = 8;
	localparam int unsigned NEST_W = 8;

	localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h27;
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;

	typedef enum logic [8:0] {
		MODE_LEAD   = 9'b0_0000_0001,
		MODE_TRAIL  = 9'b0_0000_0010,
		MODE_LIST   = 9'b0_0000_0100,
		MODE_SYM    = 9'b0_0000_1000,
		MODE_QUOTE  = 9'b0_0001_0000,
		MODE_QPAREN = 9'b0_0010_0000,
		MODE_QSYM   = 9'b0_0100_0000,
		MODE_STR    = 9'b0_1000_0000,
		MODE_ERR    = 9'b1_0000_0000
	} mode_t;

	typedef enum logic [1:0] {
		VERDICT_COMPLETE   = 2'd0,
		VERDICT_INCOMPLETE = 2'd1,
		VERDICT_ILLEGAL    = 2'd2
	} verdict_t;

	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return c inside {8'h20, [8'h09:8'h0d]};
	endfunction

	function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
		return c inside {["a":"z"], ["A":"Z"], ["0":"9"]};
	endfunction

	function automatic logic is_qsym(input logic [CHAR_W-1:0] c);
		return is_alnum(c) || (c inside {"!", "?", "=", "+", "-", "*", "/"});
	endfunction

	function automatic logic is_sym(input logic [CHAR_W-1:0] c);
		return is_qsym(c) || (c inside {"_", ".", "%", "<", ">"});
	endfunction

endpackage

### hw/rtl/sexpr_completeness_checker.sv
// s-expression completeness checker top level
//
// Takes one character per request and returns one result per character: whether the
// text so far is complete (or blank), incomplete or illegal, plus the low 8 bits of
// the open bracket count. A request with last_char set is judged with that character
// and then the checker returns to its reset state. Throughput is one character per
// cycle when out_ready does not hold the output; the character is registered in the
// first stage and its result in the second. The bound is the mode and depth update in
// the second stage, which feeds back on itself.
// MAX_DEPTH sets the deepest legal nesting; a '(' beyond it is illegal.
module sexpr_completeness_checker #(
	parameter int unsigned MAX_DEPTH = 255
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [scc_pkg::CHAR_W-1:0]    char_code,
	input  logic                          last_char,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    verdict,
	output logic [scc_pkg::NEST_W-1:0]    nesting_level
);
	import scc_pkg::*;

	localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
	localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

	logic                valid_s1;
	logic [CHAR_W-1:0]   char_s1;
	logic                last_s1;
	logic                valid_s2;
	verdict_t            verdict_s2;
	logic [NEST_W-1:0]   nest_s2;
	mode_t               mode_q;
	logic [DEPTH_W-1:0]  depth_q;

	logic                adv1;
	logic                c_blank, c_sym, c_qsym, c_lp, c_rp, c_quote, c_dquote;
	mode_t               push_mode, ba_mode, open_mode, done_mode, mode_nxt;
	logic [DEPTH_W-1:0]  push_depth, ba_depth, depth_nxt;
	verdict_t            verdict_nxt;

	assign adv1     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv1;

	assign c_blank  = is_blank(char_s1);
	assign c_sym    = is_sym(char_s1);
	assign c_qsym   = is_qsym(char_s1);
	assign c_lp     = (char_s1 == CH_LPAREN);
	assign c_rp     = (char_s1 == CH_RPAREN);
	assign c_quote  = (char_s1 == CH_QUOTE);
	assign c_dquote = (char_s1 == CH_DQUOTE);

	always_comb begin
		// opening bracket, refused at full depth
		if (depth_q >= DEPTH_MAX) begin
			push_mode  = MODE_ERR;
			push_depth = depth_q;
		end else begin
			push_mode  = MODE_LIST;
			push_depth = depth_q + DEPTH_ONE;
		end

		if (c_quote)
			open_mode = MODE_QUOTE;
		else if (c_dquote)
			open_mode = MODE_STR;
		else if (c_sym)
			open_mode = MODE_SYM;
		else
			open_mode = MODE_ERR;

		done_mode = (depth_q == '0) ? MODE_TRAIL : MODE_LIST;

		// character read between atoms
		ba_depth = depth_q;
		if (depth_q == '0) begin
			ba_mode = c_blank ? MODE_TRAIL : MODE_ERR;
		end else if (c_blank) begin
			ba_mode = MODE_LIST;
		end else if (c_lp) begin
			ba_mode  = push_mode;
			ba_depth = push_depth;
		end else if (c_rp) begin
			ba_depth = depth_q - DEPTH_ONE;
			ba_mode  = (depth_q == DEPTH_ONE) ? MODE_TRAIL : MODE_LIST;
		end else begin
			ba_mode = open_mode;
		end
	end

	always_comb begin
		mode_nxt  = mode_q;
		depth_nxt = depth_q;
		case (mode_q)
			MODE_LEAD: begin
				if (c_lp) begin
					mode_nxt  = push_mode;
					depth_nxt = push_depth;
				end else if (!c_blank) begin
					mode_nxt = open_mode;
				end
			end
			MODE_TRAIL, MODE_LIST: begin
				mode_nxt  = ba_mode;
				depth_nxt = ba_depth;
			end
			MODE_SYM: begin
				if (!c_sym) begin
					mode_nxt  = ba_mode;
					depth_nxt = ba_depth;
				end
			end
			MODE_QSYM: begin
				if (!c_qsym) begin
					mode_nxt  = ba_mode;
					depth_nxt = ba_depth;
				end
			end
			MODE_QUOTE: begin
				if (c_lp) begin
					mode_nxt = MODE_QPAREN;
				end else if (c_qsym) begin
					mode_nxt = MODE_QSYM;
				end else begin
					mode_nxt  = ba_mode;
					depth_nxt = ba_depth;
				end
			end
			MODE_QPAREN: begin
				mode_nxt = c_rp ? done_mode : MODE_ERR;
			end
			MODE_STR: begin
				if (c_dquote)
					mode_nxt = done_mode;
			end
			default: begin
				mode_nxt = MODE_ERR;
			end
		endcase

		case (mode_nxt)
			MODE_LEAD, MODE_TRAIL: verdict_nxt = VERDICT_COMPLETE;
			MODE_SYM, MODE_QSYM:
				verdict_nxt = (depth_nxt == '0) ? VERDICT_COMPLETE : VERDICT_INCOMPLETE;
			MODE_LIST, MODE_STR:   verdict_nxt = VERDICT_INCOMPLETE;
			default:               verdict_nxt = VERDICT_ILLEGAL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			mode_q   <= MODE_LEAD;
			depth_q  <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv1)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
			if (adv1) begin
				// final character returns the scanner to reset
				if (last_s1) begin
					mode_q  <= MODE_LEAD;
					depth_q <= '0;
				end else begin
					mode_q  <= mode_nxt;
					depth_q <= depth_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
		if (adv1) begin
			verdict_s2 <= verdict_nxt;
			nest_s2    <= NEST_W'(depth_nxt);
		end
	end

	assign out_valid     = valid_s2;
	assign verdict       = verdict_s2;
	assign nesting_level = nest_s2;

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_MAX)
		else $error("bracket depth above limit");

	a_lead_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_LEAD) |-> (depth_q == '0))
		else $error("leading mode with open brackets");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && last_s1) |=> (mode_q == MODE_LEAD && depth_q == '0))
		else $error("final character did not reset scanner");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 |=> out_valid)
		else $error("processed character produced no result");
`endif

endmodule
